// ===== src/four_level_priority_frame_queue_defines.svh =====
// Assertion macros shared by the frame queue RTL.
// Used by files that include it; expects clk and arst_n in scope.
`ifndef FOUR_LEVEL_PRIORITY_FRAME_QUEUE_DEFINES_SVH
`define FOUR_LEVEL_PRIORITY_FRAME_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FLPFQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define FLPFQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/flpfq_pkg.sv =====
// Types and constants of the four-level priority frame queue.
// No dependencies; imported by the controller, datapath and top level.
package flpfq_pkg;

	localparam int NUM_LEVELS = 4;
	localparam int LEVEL_BITS = 2;
	localparam int HANDLE_W   = 16;
	localparam int PRIO_IN_W  = 3;

	localparam logic OP_INSERT   = 1'b0;
	localparam logic OP_RETRIEVE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2,
		ST_BADPRIO = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LOAD
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_busy;
	} sts_t;

endpackage

// ===== src/four_level_priority_frame_queue.sv =====
// Four-level priority queue of frame handles. Each input word is an insert
// (handle plus priority 0..3, 3 highest) or a retrieve; every word yields
// exactly one result word with handle_out, prio_out and status (0 ok,
// 1 empty on retrieve, 2 level full, 3 bad priority). Inserts queue first in,
// first out within their level; a retrieve takes the oldest entry of the
// highest non-empty level. Each level holds LEVEL_DEPTH entries, kept as a
// ring in one shared entry memory; an insert into a full level is dropped
// and flagged, a priority above 3 is rejected before the full check. Only
// the low HANDLE_BITS bits of a handle are stored. Each word passes capture,
// execute with the single memory access, and load into the output register;
// a new word is taken only after the previous one has been loaded. The next
// word is taken while the previous result still waits in the output
// register, and only a held result stalls the load step. No
// clearing pass is needed after reset: entries are read only while their
// level count covers them. Depends on flpfq_pkg, flpfq_ctrl, flpfq_dpath.
module four_level_priority_frame_queue #(
	parameter int LEVEL_DEPTH = 16,
	parameter int HANDLE_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               op,
	input  logic [flpfq_pkg::PRIO_IN_W-1:0]    prio_in,
	input  logic [flpfq_pkg::HANDLE_W-1:0]     handle_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [flpfq_pkg::HANDLE_W-1:0]     handle_out,
	output logic [flpfq_pkg::LEVEL_BITS-1:0]   prio_out,
	output logic [1:0]                         status
);
	import flpfq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: advance one word through capture, execute and load
	flpfq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage, level bookkeeping and the result register
	flpfq_dpath #(
		.LEVEL_DEPTH (LEVEL_DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.op         (op),
		.prio_in    (prio_in),
		.handle_in  (handle_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.handle_out (handle_out),
		.prio_out   (prio_out),
		.status     (status)
	);

endmodule

// ===== src/flpfq_ctrl.sv =====
// Sequencer of the frame queue: accept, execute, load result.
// Depends on flpfq_pkg.
module flpfq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  flpfq_pkg::sts_t   sts,
	output flpfq_pkg::cmd_t   cmd
);
	import flpfq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		cmd.load    = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_LOAD;
			end
			S_LOAD: begin
				// hold until the output register frees up
				if (!sts.out_busy) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== src/flpfq_dpath.sv =====
// Datapath of the frame queue: per-level rings in one entry memory,
// pointers, counts, priority pick and output register. Depends on flpfq_pkg.
`include "four_level_priority_frame_queue_defines.svh"

module flpfq_dpath #(
	parameter int LEVEL_DEPTH = 16,
	parameter int HANDLE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  flpfq_pkg::cmd_t                       cmd,
	output flpfq_pkg::sts_t                       sts,
	input  logic                                  op,
	input  logic [flpfq_pkg::PRIO_IN_W-1:0]       prio_in,
	input  logic [flpfq_pkg::HANDLE_W-1:0]        handle_in,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [flpfq_pkg::HANDLE_W-1:0]        handle_out,
	output logic [flpfq_pkg::LEVEL_BITS-1:0]      prio_out,
	output logic [1:0]                            status
);
	import flpfq_pkg::*;

	localparam int SB  = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
	localparam int PW  = $clog2(LEVEL_DEPTH);
	localparam int CW  = $clog2(LEVEL_DEPTH + 1);
	localparam int AW  = LEVEL_BITS + PW;
	localparam int MEM_DEPTH = NUM_LEVELS * (1 << PW);
	localparam logic [CW-1:0] DEPTH_C  = CW'(LEVEL_DEPTH);
	localparam logic [PW-1:0] LAST_IDX = PW'(LEVEL_DEPTH - 1);

	// captured item
	logic                  op_q;
	logic [PRIO_IN_W-1:0]  prio_q;
	logic [SB-1:0]         handle_q;

	// level state
	logic [PW-1:0] rd_ptr_q [NUM_LEVELS];
	logic [PW-1:0] wr_ptr_q [NUM_LEVELS];
	logic [CW-1:0] cnt_q    [NUM_LEVELS];

	// entry memory
	logic [SB-1:0] mem [MEM_DEPTH];
	logic [SB-1:0] rdata_q;

	// pending result
	status_t               res_status_q;
	logic [LEVEL_BITS-1:0] res_prio_q;
	logic                  res_hit_q;

	// output register
	logic                  out_valid_q;
	logic [SB-1:0]         out_handle_q;
	logic [LEVEL_BITS-1:0] out_prio_q;
	status_t               out_status_q;

	// execute-cycle decode
	logic [LEVEL_BITS-1:0] ins_lvl;
	logic                  ins_bad;
	logic                  ins_full;
	logic                  do_ins;
	logic [LEVEL_BITS-1:0] sel_lvl;
	logic                  found;
	logic                  do_ret;
	logic [AW-1:0]         waddr;
	logic [AW-1:0]         raddr;

	always_comb begin
		ins_lvl  = prio_q[LEVEL_BITS-1:0];
		ins_bad  = (prio_q > PRIO_IN_W'(NUM_LEVELS - 1));
		ins_full = (cnt_q[ins_lvl] == DEPTH_C);
		do_ins   = cmd.exec && (op_q == OP_INSERT) && !ins_bad && !ins_full;
		// highest non-empty level wins
		sel_lvl = '0;
		found   = 1'b0;
		for (int l = 0; l < NUM_LEVELS; l++) begin
			if (cnt_q[l] != '0) begin
				sel_lvl = LEVEL_BITS'(l);
				found   = 1'b1;
			end
		end
		do_ret = cmd.exec && (op_q == OP_RETRIEVE) && found;
		waddr  = {ins_lvl, wr_ptr_q[ins_lvl]};
		raddr  = {sel_lvl, rd_ptr_q[sel_lvl]};
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= op;
			prio_q   <= prio_in;
			handle_q <= handle_in[SB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (do_ins) begin
			mem[waddr] <= handle_q;
		end
		if (do_ret) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < NUM_LEVELS; l++) begin
				rd_ptr_q[l] <= '0;
				wr_ptr_q[l] <= '0;
				cnt_q[l]    <= '0;
			end
		end else begin
			if (do_ins) begin
				wr_ptr_q[ins_lvl] <= (wr_ptr_q[ins_lvl] == LAST_IDX) ? '0
					: wr_ptr_q[ins_lvl] + 1'b1;
				cnt_q[ins_lvl] <= cnt_q[ins_lvl] + 1'b1;
			end
			if (do_ret) begin
				rd_ptr_q[sel_lvl] <= (rd_ptr_q[sel_lvl] == LAST_IDX) ? '0
					: rd_ptr_q[sel_lvl] + 1'b1;
				cnt_q[sel_lvl] <= cnt_q[sel_lvl] - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_hit_q  <= do_ret;
			res_prio_q <= do_ret ? sel_lvl : '0;
			if (op_q == OP_INSERT) begin
				res_status_q <= ins_bad ? ST_BADPRIO : (ins_full ? ST_FULL : ST_OK);
			end else begin
				res_status_q <= found ? ST_OK : ST_EMPTY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_handle_q <= res_hit_q ? rdata_q : '0;
			out_prio_q   <= res_prio_q;
			out_status_q <= res_status_q;
		end
	end

	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_valid    = out_valid_q;
	assign handle_out   = HANDLE_W'(out_handle_q);
	assign prio_out     = out_prio_q;
	assign status       = out_status_q;

	`FLPFQ_ASSERT_NOW(a_load_free, cmd.load, !(out_valid_q && !out_ready), "load over a held word")
	`FLPFQ_ASSERT_NOW(a_cnt_bound, 1'b1, (cnt_q[0] <= DEPTH_C) && (cnt_q[1] <= DEPTH_C) && (cnt_q[2] <= DEPTH_C) && (cnt_q[3] <= DEPTH_C), "level count above depth")
	`FLPFQ_ASSERT_NOW(a_no_write_full, do_ins, cnt_q[ins_lvl] != DEPTH_C, "write into a full level")
	`FLPFQ_ASSERT_NEXT(a_hit_ok, cmd.load && res_hit_q, out_valid_q && (out_status_q == ST_OK), "retrieve hit without ok status")

endmodule
